// ===== hw/rtl/traffic_light_controller_defines.svh =====
// Assertion macros shared by the traffic light controller RTL.
`ifndef TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH
`define TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlc assertion failed");

// Next-cycle implication, checked out of reset
`define TLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlc assertion failed");

`endif

// ===== hw/rtl/tlc_pkg.sv =====
package tlc_pkg;

  // Counter and register widths
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values
  localparam logic [CNT_W-1:0] LONG_TICKS_RST  = 16'd40000;
  localparam logic [CNT_W-1:0] AMBER_TICKS_RST = 16'd3000;
  localparam logic [CNT_W-1:0] HOLD_TICKS_RST  = 16'd3000;
  localparam logic [CNT_W-1:0] BEAT_TICKS_RST  = 16'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBER_TICKS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_TICKS  = 8'd3;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_RED      = 3'd1,
    PH_REDAMBER = 3'd2,
    PH_GREEN    = 3'd3,
    PH_AMBER    = 3'd4
  } phase_t;

  typedef struct packed {
    logic red;
    logic yellow;
    logic green;
  } lamp_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] amber_ticks;
    logic [CNT_W-1:0] hold_ticks;
    logic [CNT_W-1:0] beat_ticks;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic green_press;
    logic red_press;
    logic yellow_press;
    logic select_level;
  } item_t;

  typedef struct packed {
    lamp_t lamp;
    logic  heartbeat;
    logic  manual;
  } result_t;

endpackage

// ===== hw/rtl/tlc_cfg_regs.sv =====
module tlc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlc_pkg::CNT_W-1:0]      cfg_wdata,
  output tlc_pkg::cfg_t                  cfg
);

  tlc_pkg::cfg_t cfg_r;

  // Load the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks  <= tlc_pkg::LONG_TICKS_RST;
      cfg_r.amber_ticks <= tlc_pkg::AMBER_TICKS_RST;
      cfg_r.hold_ticks  <= tlc_pkg::HOLD_TICKS_RST;
      cfg_r.beat_ticks  <= tlc_pkg::BEAT_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tlc_pkg::CFG_LONG_TICKS:  cfg_r.long_ticks  <= cfg_wdata;
        tlc_pkg::CFG_AMBER_TICKS: cfg_r.amber_ticks <= cfg_wdata;
        tlc_pkg::CFG_HOLD_TICKS:  cfg_r.hold_ticks  <= cfg_wdata;
        tlc_pkg::CFG_BEAT_TICKS:  cfg_r.beat_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/tlc_core.sv =====
module tlc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  tlc_pkg::item_t   item,
  input  tlc_pkg::cfg_t    cfg,
  output tlc_pkg::result_t result
);

  tlc_pkg::phase_t          phase_r, phase_nxt;
  logic [tlc_pkg::CNT_W-1:0] phase_cnt_r, phase_cnt_nxt, phase_cnt_step;
  logic [tlc_pkg::CNT_W-1:0] hold_cnt_r, hold_cnt_nxt, hold_cnt_step;
  logic [tlc_pkg::CNT_W-1:0] beat_cnt_r, beat_cnt_nxt, beat_cnt_inc;
  logic                      beat_r, beat_nxt;
  logic                      mode_r, mode_nxt;
  logic                      armed_r, armed_nxt, armed_lat;
  logic                      pend_r_r, pend_y_r, pend_g_r;
  logic                      pend_r_nxt, pend_y_nxt, pend_g_nxt;
  logic                      hold_toggle, leave_manual, lamp_load;
  tlc_pkg::lamp_t            lamp_r, lamp_nxt;

  // Latch the arm flag and advance the tick counters
  always_comb begin
    armed_lat      = armed_r | item.yellow_press;
    hold_cnt_step  = hold_cnt_r;
    phase_cnt_step = phase_cnt_r;
    beat_cnt_inc   = beat_cnt_r;
    beat_cnt_nxt   = beat_cnt_r;
    beat_nxt       = beat_r;
    if (item.tick) begin
      if (armed_lat && hold_cnt_r != tlc_pkg::CNT_MAX) begin
        hold_cnt_step = hold_cnt_r + 16'd1;
      end
      if (phase_cnt_r != tlc_pkg::CNT_MAX) begin
        phase_cnt_step = phase_cnt_r + 16'd1;
      end
      if (beat_cnt_r != tlc_pkg::CNT_MAX) begin
        beat_cnt_inc = beat_cnt_r + 16'd1;
      end
      if (beat_cnt_inc >= cfg.beat_ticks) begin
        beat_cnt_nxt = '0;
        beat_nxt     = ~beat_r;
      end else begin
        beat_cnt_nxt = beat_cnt_inc;
      end
    end
  end

  // Check the select hold and toggle the mode
  always_comb begin
    hold_toggle  = armed_lat && item.select_level && (hold_cnt_step >= cfg.hold_ticks);
    leave_manual = hold_toggle && mode_r;
    mode_nxt     = mode_r ^ hold_toggle;
    armed_nxt    = armed_lat && item.select_level && !hold_toggle;
    if (armed_lat && !armed_nxt) begin
      hold_cnt_nxt = '0;
    end else begin
      hold_cnt_nxt = hold_cnt_step;
    end
  end

  // Phase sequencer next state
  always_comb begin
    phase_nxt     = phase_r;
    phase_cnt_nxt = phase_cnt_step;
    lamp_load     = 1'b0;
    if (!mode_r) begin
      unique case (phase_r)
        tlc_pkg::PH_RED: begin
          if (phase_cnt_step >= cfg.long_ticks) begin
            phase_nxt     = tlc_pkg::PH_REDAMBER;
            phase_cnt_nxt = '0;
            lamp_load     = 1'b1;
          end
        end
        tlc_pkg::PH_REDAMBER: begin
          if (phase_cnt_step >= cfg.amber_ticks) begin
            phase_nxt     = tlc_pkg::PH_GREEN;
            phase_cnt_nxt = '0;
            lamp_load     = 1'b1;
          end
        end
        tlc_pkg::PH_GREEN: begin
          if (phase_cnt_step >= cfg.long_ticks) begin
            phase_nxt     = tlc_pkg::PH_AMBER;
            phase_cnt_nxt = '0;
            lamp_load     = 1'b1;
          end
        end
        tlc_pkg::PH_AMBER: begin
          if (phase_cnt_step >= cfg.amber_ticks) begin
            phase_nxt     = tlc_pkg::PH_RED;
            phase_cnt_nxt = '0;
            lamp_load     = 1'b1;
          end
        end
        default: begin
          // start phase: go to red, count kept
          phase_nxt = tlc_pkg::PH_RED;
          lamp_load = 1'b1;
        end
      endcase
    end
    if (leave_manual) begin
      phase_nxt     = tlc_pkg::PH_START;
      phase_cnt_nxt = '0;
    end
  end

  // Lamp outputs and latched presses
  always_comb begin
    lamp_nxt   = lamp_r;
    pend_r_nxt = pend_r_r | item.red_press;
    pend_y_nxt = pend_y_r | item.yellow_press;
    pend_g_nxt = pend_g_r | item.green_press;
    if (mode_r) begin
      priority if (pend_r_nxt) begin
        lamp_nxt   = '{red: 1'b1, yellow: 1'b0, green: 1'b0};
        pend_r_nxt = 1'b0;
      end else if (pend_y_nxt) begin
        lamp_nxt   = '{red: 1'b0, yellow: 1'b1, green: 1'b0};
        pend_y_nxt = 1'b0;
      end else if (pend_g_nxt) begin
        lamp_nxt   = '{red: 1'b0, yellow: 1'b0, green: 1'b1};
        pend_g_nxt = 1'b0;
      end
    end else if (lamp_load) begin
      lamp_nxt.red    = (phase_nxt == tlc_pkg::PH_RED) || (phase_nxt == tlc_pkg::PH_REDAMBER);
      lamp_nxt.yellow = (phase_nxt == tlc_pkg::PH_REDAMBER) || (phase_nxt == tlc_pkg::PH_AMBER);
      lamp_nxt.green  = (phase_nxt == tlc_pkg::PH_GREEN);
    end
    if (leave_manual) begin
      lamp_nxt = '0;
    end
  end

  // Commit state for each transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tlc_pkg::PH_START;
      phase_cnt_r <= '0;
      hold_cnt_r  <= '0;
      beat_cnt_r  <= '0;
      beat_r      <= 1'b0;
      mode_r      <= 1'b0;
      armed_r     <= 1'b0;
      pend_r_r    <= 1'b0;
      pend_y_r    <= 1'b0;
      pend_g_r    <= 1'b0;
      lamp_r      <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      beat_cnt_r  <= beat_cnt_nxt;
      beat_r      <= beat_nxt;
      mode_r      <= mode_nxt;
      armed_r     <= armed_nxt;
      pend_r_r    <= pend_r_nxt;
      pend_y_r    <= pend_y_nxt;
      pend_g_r    <= pend_g_nxt;
      lamp_r      <= lamp_nxt;
    end
  end

  assign result.lamp      = lamp_nxt;
  assign result.heartbeat = beat_nxt;
  assign result.manual    = mode_nxt;

endmodule

// ===== hw/rtl/traffic_light_controller.sv =====
// Traffic light controller.
// Input channel: one transaction per sample (in_tick, three button press
// flags, in_select_level) on in_valid / in_stall. Output channel: one
// transaction per sample with the three lamp drives, the heartbeat LED and
// the mode flag on out_valid / out_stall.
// Each sample is captured in an input register, runs through the mode,
// phase and hold logic, and lands in the result register, from which
// out_valid is driven; one sample is taken every cycle as long as the
// result side keeps up.
// When out_stall holds the result register full, the sample in the input
// register waits and in_stall follows out_stall in the same cycle; with the
// input register empty a new sample is still taken.
// Registers 0..3 (phase, amber, hold, heartbeat ticks) are written through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write them only while
// no transaction is in flight (not enforced); unknown indexes are dropped.
// Synchronous reset empties both registers, reloads the default tick
// counts and restarts the light at the start phase in automatic mode.
`include "traffic_light_controller_defines.svh"

module traffic_light_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_tick,
  input  logic                          in_green_press,
  input  logic                          in_red_press,
  input  logic                          in_yellow_press,
  input  logic                          in_select_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_red_lamp,
  output logic                          out_yellow_lamp,
  output logic                          out_green_lamp,
  output logic                          out_heartbeat_led,
  output logic                          out_manual_mode,
  input  logic                          cfg_wr_en,
  input  logic [tlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlc_pkg::CNT_W-1:0]     cfg_wdata
);

  tlc_pkg::cfg_t    cfg;
  tlc_pkg::item_t   item_r;
  tlc_pkg::result_t result, result_r;
  logic             in_valid_r, out_valid_r;
  logic             out_free, step_en, in_take;

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  tlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{tick: in_tick, green_press: in_green_press, red_press: in_red_press,
                  yellow_press: in_yellow_press, select_level: in_select_level};
    end
  end

  tlc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red_lamp      = result_r.lamp.red;
  assign out_yellow_lamp   = result_r.lamp.yellow;
  assign out_green_lamp    = result_r.lamp.green;
  assign out_heartbeat_led = result_r.heartbeat;
  assign out_manual_mode   = result_r.manual;

  `TLC_ASSERT_NOW(a_no_red_green, out_valid_r, !(out_red_lamp && out_green_lamp))
  `TLC_ASSERT_NEXT(a_move_forward, in_valid_r && !out_valid_r, out_valid_r)
  `TLC_ASSERT_NEXT(a_drain_empty, out_valid_r && !out_stall && !in_valid_r, !out_valid_r)

endmodule
